// File: rtl/core/ddte_pkg.sv
// Shared types, widths and code constants of the delta-of-delta timestamp encoder.
package ddte_pkg;

   localparam int COLUMN_W = 6;
   localparam int STAMP_W  = 31;
   localparam int VALUE_W  = 32;
   localparam int WORD_W   = 36;
   localparam int LEN_W    = 6;
   localparam int KIND_W   = 2;

   // Depth of the queue between front and back.
   localparam int QUEUE_DEPTH = 2;

   // Result kinds.
   localparam logic [KIND_W-1:0] KIND_RAW   = 2'd0;
   localparam logic [KIND_W-1:0] KIND_DELTA = 2'd1;
   localparam logic [KIND_W-1:0] KIND_DOD   = 2'd2;

   // Prefix codes.
   localparam logic [1:0] PFX_7  = 2'b10;
   localparam logic [2:0] PFX_9  = 3'b110;
   localparam logic [3:0] PFX_12 = 4'b1110;
   localparam logic [3:0] PFX_32 = 4'b1111;

   // Code lengths.
   localparam logic [LEN_W-1:0] LEN_ZERO = 6'd1;
   localparam logic [LEN_W-1:0] LEN_7    = 6'd9;
   localparam logic [LEN_W-1:0] LEN_9    = 6'd12;
   localparam logic [LEN_W-1:0] LEN_12   = 6'd16;
   localparam logic [LEN_W-1:0] LEN_32   = 6'd36;

   // Value ranges of the short codes.
   localparam logic signed [VALUE_W-1:0] LIM7_LO  = -32'sd64;
   localparam logic signed [VALUE_W-1:0] LIM7_HI  = 32'sd63;
   localparam logic signed [VALUE_W-1:0] LIM9_LO  = -32'sd256;
   localparam logic signed [VALUE_W-1:0] LIM9_HI  = 32'sd255;
   localparam logic signed [VALUE_W-1:0] LIM12_LO = -32'sd2048;
   localparam logic signed [VALUE_W-1:0] LIM12_HI = 32'sd2047;

   typedef struct packed {
      logic [COLUMN_W-1:0] column;
      logic [STAMP_W-1:0]  stamp;
   } item_type;

endpackage

// File: rtl/core/ddte_if.sv
// Handshake interfaces of the input and result channels.
interface ddte_req_if;
   import ddte_pkg::*;
   logic                valid;
   logic                ready;
   logic [COLUMN_W-1:0] column;
   logic [STAMP_W-1:0]  stamp;
   modport source (output valid, output column, output stamp, input ready);
   modport sink (input valid, input column, input stamp, output ready);
endinterface

interface ddte_rsp_if;
   import ddte_pkg::*;
   logic                valid;
   logic                ready;
   logic [COLUMN_W-1:0] column_out;
   logic [KIND_W-1:0]   kind;
   logic [VALUE_W-1:0]  encoded_value;
   logic [WORD_W-1:0]   code_word;
   logic [LEN_W-1:0]    code_length;
   modport source (output valid, output column_out, output kind, output encoded_value,
                   output code_word, output code_length, input ready);
   modport sink (input valid, input column_out, input kind, input encoded_value,
                 input code_word, input code_length, output ready);
endinterface

// File: rtl/core/ddte_front.sv
// Front part: accepts input items, drops unknown columns, pushes the rest into the queue.
module ddte_front #(
   parameter int COLUMNS = 64
) (
   ddte_req_if.sink            req,
   input  logic                q_full,
   output logic                push,
   output ddte_pkg::item_type  push_item
);
   import ddte_pkg::*;

   localparam bit ALL_COLUMNS = (COLUMNS >= (1 << COLUMN_W));

   logic in_range;

   assign in_range         = ALL_COLUMNS || (int'(req.column) < COLUMNS);
   assign req.ready        = !q_full;
   assign push             = req.valid && !q_full && in_range;
   assign push_item.column = req.column;
   assign push_item.stamp  = req.stamp;

endmodule

// File: rtl/core/ddte_queue.sv
// Short item queue between the front and back parts.
module ddte_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  ddte_pkg::item_type  push_item,
   output logic                full,
   input  logic                pop,
   output logic                not_empty,
   output ddte_pkg::item_type  pop_item
);
   import ddte_pkg::*;

   localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CW = $clog2(QUEUE_DEPTH + 1);

   item_type        slot_ff [QUEUE_DEPTH];
   logic [PW-1:0]   wr_ptr_ff;
   logic [PW-1:0]   rd_ptr_ff;
   logic [CW-1:0]   count_ff;

   assign full      = (count_ff == CW'(QUEUE_DEPTH));
   assign not_empty = (count_ff != '0);
   assign pop_item  = slot_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
         end
         if (push && !pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (pop && !push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

endmodule

// File: rtl/core/ddte_back.sv
// Back part: per-column state, delta-of-delta arithmetic, prefix coding and result register.
module ddte_back #(
   parameter int COLUMNS = 64
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                q_not_empty,
   input  ddte_pkg::item_type  q_item,
   output logic                pop,
   ddte_rsp_if.source          rsp
);
   import ddte_pkg::*;

   localparam int DEPTH = (COLUMNS < (1 << COLUMN_W)) ? COLUMNS : (1 << COLUMN_W);
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   typedef struct packed {
      logic [WORD_W-1:0] word;
      logic [LEN_W-1:0]  len;
   } code_type;

   function automatic code_type encode(input logic [VALUE_W-1:0] v);
      code_type             c;
      logic signed [VALUE_W-1:0] s;
      s = signed'(v);
      if (v == '0) begin
         c.word = '0;
         c.len  = LEN_ZERO;
      end else if (s >= LIM7_LO && s <= LIM7_HI) begin
         c.word = {27'd0, PFX_7, v[6:0]};
         c.len  = LEN_7;
      end else if (s >= LIM9_LO && s <= LIM9_HI) begin
         c.word = {24'd0, PFX_9, v[8:0]};
         c.len  = LEN_9;
      end else if (s >= LIM12_LO && s <= LIM12_HI) begin
         c.word = {20'd0, PFX_12, v[11:0]};
         c.len  = LEN_12;
      end else begin
         c.word = {PFX_32, v};
         c.len  = LEN_32;
      end
      return c;
   endfunction

   // Stamp and delta of each column, stored together.
   logic [2*VALUE_W-1:0] mem [DEPTH];

   // Phase flags, cleared by reset.
   logic [DEPTH-1:0] seen_ff;
   logic [DEPTH-1:0] twice_ff;

   // Stage 1: read issued.
   logic                 s1_v_ff;
   item_type             s1_item_ff;
   logic [2*VALUE_W-1:0] s1_rd_ff;

   // Stage 2: arithmetic and write back.
   logic                 s2_v_ff;
   item_type             s2_item_ff;
   logic [2*VALUE_W-1:0] s2_rd_ff;

   // Last write, forwarded to the next item.
   logic                 lw_v_ff;
   logic [AW-1:0]        lw_idx_ff;
   logic [2*VALUE_W-1:0] lw_data_ff;

   // Stage 3: coding.
   logic                 s3_v_ff;
   logic [COLUMN_W-1:0]  s3_col_ff;
   logic [KIND_W-1:0]    s3_kind_ff;
   logic [VALUE_W-1:0]   s3_value_ff;

   // Output register.
   logic                 out_v_ff;
   logic [COLUMN_W-1:0]  out_col_ff;
   logic [KIND_W-1:0]    out_kind_ff;
   logic [VALUE_W-1:0]   out_value_ff;
   code_type             out_code_ff;

   logic                 out_free, s3_free, s2_free, s1_free, s2_adv;
   logic [AW-1:0]        q_idx, s2_idx;
   logic                 fwd, s2_seen, s2_twice;
   logic [VALUE_W-1:0]   stamp32, prev_stamp, prev_delta, delta, value_in;
   logic [KIND_W-1:0]    kind_in;
   logic [2*VALUE_W-1:0] wdata;
   code_type             code_in;

   assign out_free = !out_v_ff || rsp.ready;
   assign s3_free  = !s3_v_ff || out_free;
   assign s2_free  = !s2_v_ff || s3_free;
   assign s1_free  = !s1_v_ff || s2_free;
   assign s2_adv   = s2_v_ff && s3_free;
   assign pop      = q_not_empty && s1_free;

   assign q_idx    = q_item.column[AW-1:0];
   assign s2_idx   = s2_item_ff.column[AW-1:0];
   assign s2_seen  = seen_ff[s2_idx];
   assign s2_twice = twice_ff[s2_idx];

   always_comb begin
      fwd        = lw_v_ff && (lw_idx_ff == s2_idx);
      prev_stamp = fwd ? lw_data_ff[2*VALUE_W-1:VALUE_W] : s2_rd_ff[2*VALUE_W-1:VALUE_W];
      prev_delta = fwd ? lw_data_ff[VALUE_W-1:0] : s2_rd_ff[VALUE_W-1:0];
      stamp32    = {1'b0, s2_item_ff.stamp};
      delta      = stamp32 - prev_stamp;
      if (!s2_seen) begin
         value_in = stamp32;
         kind_in  = KIND_RAW;
      end else if (!s2_twice) begin
         value_in = delta;
         kind_in  = KIND_DELTA;
      end else begin
         value_in = delta - prev_delta;
         kind_in  = KIND_DOD;
      end
      wdata   = {stamp32, delta};
      code_in = encode(s3_value_ff);
   end

   always_ff @(posedge clock) begin
      if (s2_adv) begin
         mem[s2_idx] <= wdata;
      end
      if (pop) begin
         s1_rd_ff <= (s2_adv && (s2_idx == q_idx)) ? wdata : mem[q_idx];
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         s1_item_ff <= q_item;
      end
      if (s2_free) begin
         s2_item_ff <= s1_item_ff;
         s2_rd_ff   <= s1_rd_ff;
      end
      if (s2_adv) begin
         lw_idx_ff  <= s2_idx;
         lw_data_ff <= wdata;
      end
      if (s3_free) begin
         s3_col_ff   <= s2_item_ff.column;
         s3_kind_ff  <= kind_in;
         s3_value_ff <= value_in;
      end
      if (out_free) begin
         out_col_ff   <= s3_col_ff;
         out_kind_ff  <= s3_kind_ff;
         out_value_ff <= s3_value_ff;
         out_code_ff  <= code_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff  <= 1'b0;
         s2_v_ff  <= 1'b0;
         s3_v_ff  <= 1'b0;
         out_v_ff <= 1'b0;
         lw_v_ff  <= 1'b0;
         seen_ff  <= '0;
         twice_ff <= '0;
      end else begin
         if (s1_free) begin
            s1_v_ff <= pop;
         end
         if (s2_free) begin
            s2_v_ff <= s1_v_ff;
         end
         if (s3_free) begin
            s3_v_ff <= s2_adv;
         end
         if (out_free) begin
            out_v_ff <= s3_v_ff;
         end
         if (s2_adv) begin
            lw_v_ff          <= 1'b1;
            seen_ff[s2_idx]  <= 1'b1;
            if (s2_seen) begin
               twice_ff[s2_idx] <= 1'b1;
            end
         end
      end
   end

   assign rsp.valid         = out_v_ff;
   assign rsp.column_out    = out_col_ff;
   assign rsp.kind          = out_kind_ff;
   assign rsp.encoded_value = out_value_ff;
   assign rsp.code_word     = out_code_ff.word;
   assign rsp.code_length   = out_code_ff.len;

   // A column can only be past its second value once it has seen a first.
   a_phase_order: assert property (@(posedge clock) disable iff (reset)
      ((twice_ff & ~seen_ff) == '0))
      else $error("column marked twice without being seen");

   // The one-bit code stands only for a zero value.
   a_zero_code: assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && rsp.code_length == LEN_ZERO) |->
      (rsp.code_word == '0 && rsp.encoded_value == '0))
      else $error("one-bit code for a nonzero value");

   // A raw first value is a 31-bit stamp and never negative.
   a_raw_positive: assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && rsp.kind == KIND_RAW) |-> !rsp.encoded_value[VALUE_W-1])
      else $error("raw value with sign bit set");

   // The long code carries the whole value after its prefix.
   a_long_code: assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && rsp.code_length == LEN_32) |->
      (rsp.code_word[WORD_W-1:VALUE_W] == PFX_32 &&
       rsp.code_word[VALUE_W-1:0] == rsp.encoded_value))
      else $error("long code does not match value");

endmodule

// File: rtl/core/delta_of_delta_timestamp_encoder.sv
// Top level of the delta-of-delta timestamp encoder.
//
// Each input item carries a column number and a 31-bit timestamp; each
// accepted item whose column is below COLUMNS yields one result item with
// the value that was encoded (the raw stamp for the first value of a column,
// the stamp difference for the second, and the difference of differences
// after that, all wrapping at 32 bits), its kind, the right-aligned prefix
// codeword and its length in bits. Items for columns at or above COLUMNS are
// dropped without a result and without touching any state. The block takes
// one item per clock cycle sustained while the result channel is not stalled;
// each item moves through the queue, the read, arithmetic and coding stages
// and the output register. The rate is set by the per-column read-modify-write
// on the stamp and delta memory: the memory read is registered, and a
// same-address bypass at the read port plus a forwarding register holding
// the last write let consecutive items of one column follow each other in
// back-to-back cycles. A two-entry queue lets the input side keep accepting
// while the result side stalls, and the result is held in an output register
// until it is taken. The per-column phase is held in flip-flops that reset
// clears at once, so there is no clearing pass after reset; the stored
// stamps and deltas need no reset since the phase gates every read of them.
module delta_of_delta_timestamp_encoder #(
   parameter int COLUMNS = 64
) (
   input  logic       clock,
   input  logic       reset,
   ddte_req_if.sink   req,
   ddte_rsp_if.source rsp
);
   import ddte_pkg::*;

   // Queue handshake between the front and back parts.
   logic     push;
   item_type push_item;
   logic     q_full;
   logic     pop;
   logic     q_not_empty;
   item_type q_item;

   // The front part accepts items and filters out columns that have no state.
   ddte_front #(
      .COLUMNS   (COLUMNS)
   ) u_front (
      .req       (req),
      .q_full    (q_full),
      .push      (push),
      .push_item (push_item)
   );

   // The queue decouples acceptance from the encoding pipeline.
   ddte_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .full      (q_full),
      .pop       (pop),
      .not_empty (q_not_empty),
      .pop_item  (q_item)
   );

   // The back part keeps the per-column state, computes and codes each value.
   ddte_back #(
      .COLUMNS     (COLUMNS)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .q_not_empty (q_not_empty),
      .q_item      (q_item),
      .pop         (pop),
      .rsp         (rsp)
   );

endmodule

// File: bench/ddte_code_checker.sv
// Watches both channels of the timestamp encoder, predicts each codeword and compares.
module ddte_code_checker #(
   parameter int COLUMNS = 64
) (
   input  logic clock,
   input  logic reset,
   ddte_req_if  req,
   ddte_rsp_if  rsp,
   output int   mismatches,
   output int   outstanding
);
   import ddte_pkg::*;

   typedef enum logic [1:0] {
      SEEN_NONE = 2'd0,
      SEEN_ONE  = 2'd1,
      SEEN_MANY = 2'd2
   } seen_type;

   typedef struct packed {
      logic [COLUMN_W-1:0] column;
      logic [KIND_W-1:0]   kind;
      logic [VALUE_W-1:0]  value;
      logic [WORD_W-1:0]   word;
      logic [LEN_W-1:0]    length;
   } code_type;

   seen_type           column_seen [COLUMNS];
   logic [VALUE_W-1:0] prior_stamp [COLUMNS];
   logic [VALUE_W-1:0] prior_delta [COLUMNS];
   code_type           expected_codes [$];

   task automatic report(input string field, input logic [63:0] want, input logic [63:0] got);
      $display("mismatch in %s: expected %0h, got %0h", field, want, got);
      mismatches = mismatches + 1;
   endtask

   // Prefix code of one 32-bit value, right aligned.
   function automatic code_type prefix_code(input logic [COLUMN_W-1:0] column,
                                            input logic [KIND_W-1:0] kind,
                                            input logic [VALUE_W-1:0] value);
      code_type                  code;
      logic signed [VALUE_W-1:0] s;
      s           = signed'(value);
      code.column = column;
      code.kind   = kind;
      code.value  = value;
      if (value == '0) begin
         code.word   = '0;
         code.length = LEN_ZERO;
      end else if (s >= LIM7_LO && s <= LIM7_HI) begin
         code.word   = {27'd0, PFX_7, value[6:0]};
         code.length = LEN_7;
      end else if (s >= LIM9_LO && s <= LIM9_HI) begin
         code.word   = {24'd0, PFX_9, value[8:0]};
         code.length = LEN_9;
      end else if (s >= LIM12_LO && s <= LIM12_HI) begin
         code.word   = {20'd0, PFX_12, value[11:0]};
         code.length = LEN_12;
      end else begin
         code.word   = {PFX_32, value};
         code.length = LEN_32;
      end
      return code;
   endfunction

   always @(posedge clock) begin
      logic [VALUE_W-1:0] stamp;
      logic [VALUE_W-1:0] delta;
      logic [VALUE_W-1:0] value;
      logic [KIND_W-1:0]  kind;
      code_type           want;
      if (reset) begin
         foreach (column_seen[i]) column_seen[i] = SEEN_NONE;
         expected_codes.delete();
         mismatches = 0;
      end else begin
         if (rsp.valid && rsp.ready) begin
            if (expected_codes.size() == 0) begin
               report("result with nothing pending", '0, 64'(rsp.code_word));
            end else begin
               want = expected_codes.pop_front();
               if (rsp.column_out !== want.column)
                  report("column_out", 64'(want.column), 64'(rsp.column_out));
               if (rsp.kind !== want.kind)
                  report("kind", 64'(want.kind), 64'(rsp.kind));
               if (rsp.encoded_value !== want.value)
                  report("encoded_value", 64'(want.value), 64'(rsp.encoded_value));
               if (rsp.code_word !== want.word)
                  report("code_word", 64'(want.word), 64'(rsp.code_word));
               if (rsp.code_length !== want.length)
                  report("code_length", 64'(want.length), 64'(rsp.code_length));
            end
         end
         if (req.valid && req.ready && req.column < COLUMNS) begin
            stamp = {1'b0, req.stamp};
            case (column_seen[req.column])
               SEEN_NONE: begin
                  value = stamp;
                  kind  = KIND_RAW;
                  column_seen[req.column] = SEEN_ONE;
               end
               SEEN_ONE: begin
                  delta = stamp - prior_stamp[req.column];
                  value = delta;
                  kind  = KIND_DELTA;
                  prior_delta[req.column] = delta;
                  column_seen[req.column] = SEEN_MANY;
               end
               default: begin
                  delta = stamp - prior_stamp[req.column];
                  value = delta - prior_delta[req.column];
                  kind  = KIND_DOD;
                  prior_delta[req.column] = delta;
                  column_seen[req.column] = SEEN_MANY;
               end
            endcase
            prior_stamp[req.column] = stamp;
            expected_codes.insert(expected_codes.size(), prefix_code(req.column, kind, value));
         end
      end
      outstanding <= expected_codes.size();
   end

endmodule

// File: bench/delta_of_delta_timestamp_encoder_tb.sv
// Top of the timestamp encoder testbench: clock, reset, stimulus, stalls and verdict.
module delta_of_delta_timestamp_encoder_tb;
   import ddte_pkg::*;

   localparam int NUM_COLUMNS = 64;
   // Cycles without any item moving on either channel before the run is abandoned.
   // The slowest correct stretch is the long receiver hold-off, so this leaves
   // a wide margin.
   localparam int STUCK_LIMIT = 4000;
   localparam int DRAIN_CYCLES = 12;

   logic clock = 1'b0;
   logic reset = 1'b1;

   ddte_req_if req_ch ();
   ddte_rsp_if rsp_ch ();

   int mismatches;
   int outstanding;

   // Percent of cycles in which the sender holds back and the receiver stalls.
   int send_idle  = 0;
   int recv_stall = 0;
   // Length of a requested receiver hold-off; the receiver process clears it.
   int hold_len   = 0;
   int stuck_cycles = 0;

   // Last stamp and delta sent per column, used only to shape well-formed streams.
   logic [STAMP_W-1:0] sent_stamp [NUM_COLUMNS];
   logic [STAMP_W-1:0] sent_delta [NUM_COLUMNS];

   always #10 clock = ~clock;

   delta_of_delta_timestamp_encoder #(
      .COLUMNS(NUM_COLUMNS)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req  (req_ch),
      .rsp  (rsp_ch)
   );

   ddte_code_checker #(
      .COLUMNS(NUM_COLUMNS)
   ) checker_i (
      .clock      (clock),
      .reset      (reset),
      .req        (req_ch),
      .rsp        (rsp_ch),
      .mismatches (mismatches),
      .outstanding(outstanding)
   );

   // Offers one item, idling first at the current sender rate, and returns at the
   // edge where it was accepted. Valid stays high when the next item follows at once.
   task automatic offer(input logic [COLUMN_W-1:0] column, input logic [STAMP_W-1:0] stamp);
      while ($urandom_range(99) < send_idle) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid  <= 1'b1;
      req_ch.column <= column;
      req_ch.stamp  <= stamp;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      sent_delta[column] = stamp - sent_stamp[column];
      sent_stamp[column] = stamp;
   endtask

   // Mostly a steady stream per column: the last delta repeated with a jitter that
   // lands on and around each code-range boundary. A few items are fully random
   // stamps, which break the stream and exercise the 32-bit code.
   task automatic random_item();
      logic [COLUMN_W-1:0] column;
      logic [STAMP_W-1:0]  stamp;
      int                  jitter;
      // A handful of hot columns keeps consecutive items on the same column often,
      // which is where the read-modify-write forwarding matters.
      if ($urandom_range(3) == 0)
         column = COLUMN_W'($urandom_range(NUM_COLUMNS - 1));
      else
         column = COLUMN_W'($urandom_range(7));
      if ($urandom_range(99) < 8) begin
         stamp = STAMP_W'($urandom);
      end else begin
         case ($urandom_range(5))
            1: jitter = int'($urandom_range(129)) - 65;
            2: jitter = int'($urandom_range(513)) - 257;
            3: jitter = int'($urandom_range(4097)) - 2049;
            4: jitter = int'($urandom_range(200000)) - 100000;
            default: jitter = 0;
         endcase
         stamp = sent_stamp[column] + sent_delta[column] + STAMP_W'(jitter);
      end
      offer(column, stamp);
   endtask

   // Receiver: stalls at the current rate, or holds off for a requested stretch.
   initial begin
      rsp_ch.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_len > 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (hold_len - 1) @(posedge clock);
            hold_len = 0;
         end else begin
            rsp_ch.ready <= ($urandom_range(99) >= recv_stall);
         end
      end
   end

   // Watchdog: any accepted item on either side restarts the count.
   always @(posedge clock) begin
      if (reset) begin
         stuck_cycles <= 0;
      end else if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         stuck_cycles <= 0;
      end else if (stuck_cycles >= STUCK_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end else begin
         stuck_cycles <= stuck_cycles + 1;
      end
   end

   initial begin
      req_ch.valid  = 1'b0;
      req_ch.column = '0;
      req_ch.stamp  = '0;
      foreach (sent_stamp[i]) begin
         sent_stamp[i] = '0;
         sent_delta[i] = '0;
      end

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Directed part, back to back with the receiver always ready.
      // Zero stamp on a fresh column, then a zero delta and a zero delta of delta:
      // each of these is the single-bit code.
      offer(6'd0, 31'd0);
      offer(6'd0, 31'd0);
      offer(6'd0, 31'd0);
      // Largest stamp on the last column, then the largest drop and rise.
      offer(6'd63, 31'h7FFF_FFFF);
      offer(6'd63, 31'd0);
      offer(6'd63, 31'h7FFF_FFFF);
      // Raw values on both sides of each positive range boundary.
      offer(6'd1, 31'd63);
      offer(6'd2, 31'd64);
      offer(6'd3, 31'd255);
      offer(6'd4, 31'd256);
      offer(6'd5, 31'd2047);
      offer(6'd6, 31'd2048);
      // Negative delta of -64, then deltas of delta -65 and -256.
      offer(6'd7, 31'd5000);
      offer(6'd7, 31'd4936);
      offer(6'd7, 31'd4807);
      offer(6'd7, 31'd4422);
      // Delta 100, delta of delta 0, -2048 and -1.
      offer(6'd8, 31'd100000);
      offer(6'd8, 31'd100100);
      offer(6'd8, 31'd100200);
      offer(6'd8, 31'd98252);
      offer(6'd8, 31'd96303);

      // Random part in several idling regimes.
      repeat (300) random_item();
      send_idle = 64;
      repeat (300) random_item();
      send_idle  = 0;
      recv_stall = 64;
      repeat (300) random_item();
      send_idle  = 38;
      recv_stall = 38;
      repeat (300) random_item();

      // Long receiver hold-off while the sender keeps offering, so the internal
      // queue fills and the input side has to stall.
      send_idle  = 0;
      recv_stall = 0;
      hold_len   = 80;
      repeat (100) random_item();

      req_ch.valid <= 1'b0;
      while (outstanding != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatches == 0 && outstanding == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

// File: delta_of_delta_timestamp_encoder.f
rtl/core/ddte_pkg.sv
rtl/core/ddte_if.sv
rtl/core/ddte_front.sv
rtl/core/ddte_queue.sv
rtl/core/ddte_back.sv
rtl/core/delta_of_delta_timestamp_encoder.sv
bench/ddte_code_checker.sv
bench/delta_of_delta_timestamp_encoder_tb.sv
